/* hdl/lyapunov_exponent_pixel_unit_defines.svh */
// Assertion macros for the Lyapunov pixel unit.
`ifndef LYAPUNOV_EXPONENT_PIXEL_UNIT_DEFINES_SVH
`define LYAPUNOV_EXPONENT_PIXEL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LEPU_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");
`define LEPU_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define LEPU_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define LEPU_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* hdl/lepu_pkg.sv */
// Shared types, constants and helpers for the Lyapunov pixel unit.
package lepu_pkg;
	localparam int DEF_MAX_SEQ_LEN = 32;
	localparam int SUM_W = 48;
	localparam int CNT_W = 22;
	localparam int OUT_W = 24;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [23:0] ZERO_TERM = 24'hE0_0000;   // -32.0 in Q.16

	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_ITER = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_U, ST_MUL_X, ST_MUL_D, ST_NORM, ST_SQR, ST_ACC,
		ST_DIV_GO, ST_DIV_WAIT, ST_ZERO
	} lepu_state_t;

	typedef struct packed {
		logic load;
		logic mul_u;
		logic mul_x;
		logic mul_d;
		logic norm;
		logic sqr;
		logic acc;
		logic use_b;
		logic div_start;
		logic res_div;
		logic res_zero;
	} lepu_cmd_t;

	typedef struct packed {
		logic div_done;
	} lepu_sts_t;

	function automatic logic [30:0] sat_one(input logic [30:0] v);
		return (v > ONE_Q30) ? ONE_Q30 : v;
	endfunction
endpackage

/* hdl/lepu_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
module lepu_div
	import lepu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

/* hdl/lepu_dp.sv */
// Datapath: map step, derivative, log2 by repeated squaring, sum and result register.
module lepu_dp
	import lepu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lepu_cmd_t        cmd,
	output lepu_sts_t        sts,
	input  logic [30:0]      rate_a,
	input  logic [30:0]      rate_b,
	input  logic [30:0]      start_value,
	input  logic [5:0]       seq_len,
	input  logic [15:0]      iter_count,
	output logic [OUT_W-1:0] exponent,
	output logic             hit_zero
);
	logic [30:0]      ra_q, rb_q, x_q, u_q;
	logic [61:0]      d_q;
	logic [31:0]      m_q;
	logic [5:0]       p_q;
	logic [15:0]      frac_q;
	logic [SUM_W-1:0] sum_q;
	logic             zero_q;
	logic [CNT_W-1:0] count_q;
	logic [OUT_W-1:0] exponent_q;
	logic             hit_zero_q;

	logic [30:0] rsel;
	logic [31:0] twox, span;
	logic [31:0] op_a, op_b;
	logic [63:0] prod;
	logic [35:0] xn;
	logic [5:0]  p_new;
	logic [61:0] m_wide;
	logic [7:0]  p_off;
	logic [23:0] term;
	logic        div_done;
	logic [SUM_W-1:0] quotient;

	assign rsel = cmd.use_b ? rb_q : ra_q;
	assign twox = {x_q, 1'b0};
	assign span = (twox > {1'b0, ONE_Q30}) ? (twox - {1'b0, ONE_Q30})
		: ({1'b0, ONE_Q30} - twox);

	// one shared multiplier for all four product kinds
	always_comb begin
		op_a = m_q;
		op_b = m_q;
		if (cmd.mul_u) begin
			op_a = {1'b0, x_q};
			op_b = {1'b0, ONE_Q30 - x_q};
		end else if (cmd.mul_x) begin
			op_a = {1'b0, rsel};
			op_b = {1'b0, u_q};
		end else if (cmd.mul_d) begin
			op_a = {1'b0, rsel};
			op_b = span;
		end
	end
	assign prod = op_a * op_b;
	assign xn = prod[63:28];

	// top set bit of d and normalized 32-bit mantissa
	always_comb begin
		p_new = '0;
		for (int i = 0; i < 62; i++)
			if (d_q[i])
				p_new = 6'(i);
	end
	assign m_wide = (p_new >= 6'd31) ? (d_q >> (p_new - 6'd31)) : (d_q << (6'd31 - p_new));

	assign p_off = {2'b00, p_q} - 8'd58;
	assign term = (d_q == '0) ? ZERO_TERM : {p_off, frac_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q <= sat_one(rate_a);
			rb_q <= sat_one(rate_b);
			x_q <= sat_one(start_value);
			sum_q <= '0;
			zero_q <= 1'b0;
			count_q <= CNT_W'(seq_len) * CNT_W'(iter_count);
		end
		if (cmd.mul_u)
			u_q <= prod[60:30];
		if (cmd.mul_x)
			x_q <= (xn > {5'd0, ONE_Q30}) ? ONE_Q30 : xn[30:0];
		if (cmd.mul_d)
			d_q <= prod[61:0];
		if (cmd.norm) begin
			p_q <= p_new;
			m_q <= m_wide[31:0];
			frac_q <= '0;
		end
		if (cmd.sqr) begin
			if (prod[63]) begin
				m_q <= prod[63:32];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				m_q <= prod[62:31];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		if (cmd.acc) begin
			sum_q <= sum_q + {{(SUM_W-24){term[23]}}, term};
			if (d_q == '0)
				zero_q <= 1'b1;
		end
		if (cmd.res_div) begin
			exponent_q <= quotient[OUT_W-1:0];
			hit_zero_q <= zero_q;
		end else if (cmd.res_zero) begin
			exponent_q <= '0;
			hit_zero_q <= 1'b0;
		end
	end

	lepu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.div_done = div_done;
	assign exponent = exponent_q;
	assign hit_zero = hit_zero_q;
endmodule

/* hdl/lepu_ctrl.sv */
// Controller: sequences map steps, squarings, the divide and the output handshake.
module lepu_ctrl
	import lepu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] seq_pattern,
	input  logic [5:0]  seq_len,
	input  logic [15:0] iter_count,
	input  lepu_sts_t   sts,
	output lepu_cmd_t   cmd,
	output logic        busy
);
	lepu_state_t state_q, state_d;
	logic [5:0]  pos_q;
	logic [15:0] iter_q;
	logic [3:0]  sq_q;
	logic        out_valid_q;
	logic        out_free;
	logic        zero_cnt;
	logic        pos_last;
	logic        last_step;

	assign out_free = !out_valid_q || m_tready;
	assign zero_cnt = (seq_len == '0) || (iter_count == '0);
	assign pos_last = (pos_q == seq_len - 6'd1);
	assign last_step = pos_last && (iter_q == iter_count - 16'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = zero_cnt ? ST_ZERO : ST_MUL_U;
			ST_MUL_U:    state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_NORM;
			ST_NORM:     state_d = ST_SQR;
			ST_SQR:      if (sq_q == 4'hF) state_d = ST_ACC;
			ST_ACC:      state_d = last_step ? ST_DIV_GO : ST_MUL_U;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (sts.div_done && out_free) state_d = ST_IDLE;
			ST_ZERO:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL_U:    cmd.mul_u = 1'b1;
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				cmd.use_b = seq_pattern[pos_q[4:0]];
			end
			ST_MUL_D: begin
				cmd.mul_d = 1'b1;
				cmd.use_b = seq_pattern[pos_q[4:0]];
			end
			ST_NORM:     cmd.norm = 1'b1;
			ST_SQR:      cmd.sqr = 1'b1;
			ST_ACC:      cmd.acc = 1'b1;
			ST_DIV_GO:   cmd.div_start = 1'b1;
			ST_DIV_WAIT: cmd.res_div = sts.div_done && out_free;
			ST_ZERO:     cmd.res_zero = out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			iter_q <= '0;
			sq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				pos_q <= '0;
				iter_q <= '0;
				sq_q <= '0;
			end
			if (cmd.sqr)
				sq_q <= sq_q + 4'd1;
			if (cmd.acc) begin
				if (pos_last) begin
					pos_q <= '0;
					iter_q <= iter_q + 16'd1;
				end else begin
					pos_q <= pos_q + 6'd1;
				end
			end
			if (cmd.res_div || cmd.res_zero)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign busy = (state_q != ST_IDLE);
endmodule

/* hdl/lyapunov_exponent_pixel_unit.sv */
// Lyapunov pixel unit: each map step runs on the shared 32x32 multiplier
// (3 products, 1 normalize, 16 log2 squarings, 1 accumulate).
// A new pixel is accepted only when idle; the next pixel is taken while a result waits.
// Reset: arst_n clears the controller and loads register defaults
// (pattern 2, length 2, iterations 256).
`include "lyapunov_exponent_pixel_unit_defines.svh"
module lyapunov_exponent_pixel_unit
	import lepu_pkg::*;
#(
	parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,    // rate_a[30:0], rate_b[61:31], start_value[92:62]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // exponent[23:0]
	output logic [0:0]  m_tuser,    // hit_zero[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0] seq_pattern_q;
	logic [5:0]  seq_length_q;
	logic [15:0] iter_count_q;
	logic [5:0]  seq_len;
	logic        wr_en;
	lepu_cmd_t   cmd;
	lepu_sts_t   sts;
	logic        busy;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_pattern_q <= 32'd2;
			seq_length_q <= 6'd2;
			iter_count_q <= 16'd256;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_PATTERN: seq_pattern_q <= pwdata;
				REG_LENGTH:  seq_length_q <= pwdata[5:0];
				REG_ITER:    iter_count_q <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PATTERN: prdata = seq_pattern_q;
			REG_LENGTH:  prdata = {26'd0, seq_length_q};
			REG_ITER:    prdata = {16'd0, iter_count_q};
			default:     prdata = '0;
		endcase
	end

	assign seq_len = ({1'b0, seq_length_q} > 7'(MAX_SEQ_LEN)) ? 6'(MAX_SEQ_LEN) : seq_length_q;

	lepu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.seq_pattern (seq_pattern_q),
		.seq_len     (seq_len),
		.iter_count  (iter_count_q),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	lepu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rate_a      (s_tdata[30:0]),
		.rate_b      (s_tdata[61:31]),
		.start_value (s_tdata[92:62]),
		.seq_len     (seq_len),
		.iter_count  (iter_count_q),
		.exponent    (m_tdata),
		.hit_zero    (m_tuser[0])
	);

	`LEPU_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, busy && !s_tready)
	`LEPU_ASSERT_IMPLY(a_busy_no_ready, clk, arst_n, busy, !s_tready)
endmodule
